>>> design/stes_pkg.sv
// types and constants shared by the stump threshold error scan
`timescale 1ns / 1ps
package stes_pkg;

  localparam int KEY_W = 32;
  localparam int WEIGHT_W = 16;
  localparam int SUM_W = 24;
  localparam int ERR_W = 27;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [SUM_W-1:0] TOTAL_RESET = 24'h010000;

  typedef enum logic [0:0] {
    REG_POSITIVE_TOTAL = 1'b0
  } reg_index_t;

  typedef struct packed {
    logic [KEY_W-1:0] feature_key;
    logic [WEIGHT_W-1:0] weight;
    logic label_positive;
    logic first_of_scan;
  } item_t;

  typedef struct packed {
    logic signed [ERR_W-1:0] error;
    logic polarity_negative;
  } result_t;

endpackage

>>> design/stump_threshold_error_scan.sv
// decision stump weighted error scan: input stage, error logic, result stage
//
//  channel  | signals                            | direction
//  ---------+------------------------------------+----------
//  item     | item_valid, item_ready, item       | in
//  result   | result_valid, result_ready, result | out
//  config   | psel, penable, pwrite, paddr,      | apb
//           | pwdata, prdata, pready             |
//
// one item per cycle sustained while result_ready stays high; an item passes through
// the input register, then the result register, where its result is valid.
// the running sums and tie memory update when an item moves into the result
// register, so each item sees all earlier items.
// rst (synchronous) clears sums, tie memory and both stages; total goes to 1.0.
// a stall on result backs up through the input register to item_ready.
`timescale 1ns / 1ps
module stump_threshold_error_scan #(
  parameter int FRAC_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic item_valid,
  output logic item_ready,
  input  stes_pkg::item_t item,
  output logic result_valid,
  input  logic result_ready,
  output stes_pkg::result_t result,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [stes_pkg::ADDR_W-1:0] paddr,
  input  logic [stes_pkg::DATA_W-1:0] pwdata,
  output logic [stes_pkg::DATA_W-1:0] prdata,
  output logic pready
);
  import stes_pkg::*;

  // wide enough for 2^FRAC_BITS and the full pre-fold error range, plus sign
  localparam int CW = ((FRAC_BITS > SUM_W + 1) ? FRAC_BITS : SUM_W + 1) + 3;
  localparam logic signed [CW-1:0] ONE = CW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] HALF = ONE >>> 1;

  logic [SUM_W-1:0] positive_total;
  logic [SUM_W-1:0] positive_sum;
  logic [SUM_W-1:0] negative_sum;
  logic [KEY_W-1:0] prev_key;
  logic signed [ERR_W-1:0] prev_error;
  logic prev_polarity;
  logic prev_valid;

  logic stage_valid;
  item_t stage_item;

  logic adv;
  logic cfg_write;
  logic [SUM_W-1:0] psum_eff;
  logic [SUM_W-1:0] nsum_eff;
  logic tie_hit;
  logic signed [CW-1:0] err_raw;
  logic signed [CW-1:0] err_sel;
  logic pol_sel;
  logic [SUM_W:0] add_sum;
  logic [SUM_W-1:0] sat_sum;
  result_t result_next;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite
                     && (reg_index_t'(paddr[ADDR_W-1]) == REG_POSITIVE_TOTAL);

  always_comb begin
    prdata = '0;
    if (reg_index_t'(paddr[ADDR_W-1]) == REG_POSITIVE_TOTAL) begin
      prdata = {{(DATA_W-SUM_W){1'b0}}, positive_total};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      positive_total <= TOTAL_RESET;
    end else if (cfg_write) begin
      positive_total <= pwdata[SUM_W-1:0];
    end
  end

  assign adv = stage_valid && (!result_valid || result_ready);
  assign item_ready = !stage_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage_item <= item;
    end
  end

  // first of scan clears sums and tie memory ahead of this item
  assign psum_eff = stage_item.first_of_scan ? '0 : positive_sum;
  assign nsum_eff = stage_item.first_of_scan ? '0 : negative_sum;
  assign tie_hit = !stage_item.first_of_scan && prev_valid
                   && (stage_item.feature_key == prev_key);

  always_comb begin
    err_raw = $signed({{(CW-SUM_W){1'b0}}, positive_total})
              - $signed({{(CW-SUM_W){1'b0}}, psum_eff})
              + $signed({{(CW-SUM_W){1'b0}}, nsum_eff});
    if (err_raw <= HALF) begin
      err_sel = err_raw;
      pol_sel = 1'b0;
    end else begin
      err_sel = ONE - err_raw;
      pol_sel = 1'b1;
    end
    if (tie_hit) begin
      result_next.error = prev_error;
      result_next.polarity_negative = prev_polarity;
    end else begin
      result_next.error = err_sel[ERR_W-1:0];
      result_next.polarity_negative = pol_sel;
    end
  end

  // saturating add of the weight into the sum named by the label
  always_comb begin
    if (stage_item.label_positive) begin
      add_sum = {1'b0, psum_eff} + {{(SUM_W+1-WEIGHT_W){1'b0}}, stage_item.weight};
    end else begin
      add_sum = {1'b0, nsum_eff} + {{(SUM_W+1-WEIGHT_W){1'b0}}, stage_item.weight};
    end
    sat_sum = add_sum[SUM_W] ? SUM_MAX : add_sum[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      positive_sum <= '0;
      negative_sum <= '0;
      prev_key <= '0;
      prev_error <= '0;
      prev_polarity <= 1'b0;
      prev_valid <= 1'b0;
    end else if (adv) begin
      positive_sum <= stage_item.label_positive ? sat_sum : psum_eff;
      negative_sum <= stage_item.label_positive ? nsum_eff : sat_sum;
      prev_key <= stage_item.feature_key;
      prev_error <= result_next.error;
      prev_polarity <= result_next.polarity_negative;
      prev_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result <= result_next;
    end
  end

  a_adv_fills_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> result_valid)
    else $error("result register not loaded after stage transfer");

  a_tie_repeats: assert property (@(posedge clk) disable iff (rst)
    adv && tie_hit |=> (result.error == $past(prev_error))
                       && (result.polarity_negative == $past(prev_polarity)))
    else $error("tied key did not repeat previous result");

  a_empty_stage_ready: assert property (@(posedge clk) disable iff (rst)
    !stage_valid |-> item_ready)
    else $error("empty input stage refused a transfer");

  a_tie_memory_set: assert property (@(posedge clk) disable iff (rst)
    adv |=> prev_valid && (prev_key == $past(stage_item.feature_key)))
    else $error("tie memory not updated");

endmodule

>>> bench/tb_stump_threshold_error_scan.sv
// self-checking testbench for the stump threshold error scan
`timescale 1ns / 1ps
module tb_stump_threshold_error_scan;
  import stes_pkg::*;

  localparam int FRAC = 16;
  localparam longint ONE = longint'(1) << FRAC;
  localparam longint HALF = longint'(1) << (FRAC - 1);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  item_t item = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  result_t result;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // scan state mirrored by the predictor
  logic [SUM_W-1:0] model_total = TOTAL_RESET;
  logic [SUM_W-1:0] model_pos_sum = '0;
  logic [SUM_W-1:0] model_neg_sum = '0;
  logic [KEY_W-1:0] model_prev_key = '0;
  result_t model_prev = '0;
  bit model_prev_valid = 1'b0;

  item_t pending_items[$];
  result_t expected_results[$];
  int send_idle_pct = 11;
  int recv_idle_pct = 59;
  int mismatches = 0;

  stump_threshold_error_scan #(.FRAC_BITS(FRAC)) dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [SUM_W-1:0] sum_sat(logic [SUM_W-1:0] acc,
                                               logic [WEIGHT_W-1:0] w);
    logic [SUM_W:0] s;
    s = {1'b0, acc} + w;
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

  // error of a threshold just below this example, then count the example
  function automatic result_t scan_error(item_t it);
    longint err_wide;
    result_t r;
    if (it.first_of_scan) begin
      model_pos_sum = '0;
      model_neg_sum = '0;
      model_prev_valid = 1'b0;
    end
    if (model_prev_valid && it.feature_key == model_prev_key) begin
      r = model_prev;
    end else begin
      err_wide = longint'(model_total) - longint'(model_pos_sum) + longint'(model_neg_sum);
      if (err_wide <= HALF) begin
        r.polarity_negative = 1'b0;
      end else begin
        err_wide = ONE - err_wide;
        r.polarity_negative = 1'b1;
      end
      r.error = err_wide[ERR_W-1:0];
    end
    if (it.label_positive) begin
      model_pos_sum = sum_sat(model_pos_sum, it.weight);
    end else begin
      model_neg_sum = sum_sat(model_neg_sum, it.weight);
    end
    model_prev_key = it.feature_key;
    model_prev = r;
    model_prev_valid = 1'b1;
    return r;
  endfunction

  // item driver: once the current transfer completes, a new one is offered unless a random idle draw holds it back
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && item_ready) begin
        expected_results.push_back(scan_error(item));
      end
      if (!item_valid || item_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          item_valid <= 1'b1;
          item <= pending_items.pop_front();
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t exp_r;
    if (!rst && result_valid && result_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual error %0d polarity %0b",
                 $time, result.error, result.polarity_negative);
        mismatches++;
      end else begin
        exp_r = expected_results.pop_front();
        if (result.error !== exp_r.error) begin
          $display("%0t: error mismatch, expected %0d, actual %0d",
                   $time, exp_r.error, result.error);
          mismatches++;
        end
        if (result.polarity_negative !== exp_r.polarity_negative) begin
          $display("%0t: polarity mismatch, expected %0b, actual %0b",
                   $time, exp_r.polarity_negative, result.polarity_negative);
          mismatches++;
        end
      end
    end
  end

  task automatic write_total(logic [SUM_W-1:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * REG_POSITIVE_TOTAL);
    pwdata <= DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_total = value;
  endtask

  function automatic void push_item(logic [KEY_W-1:0] key, logic [WEIGHT_W-1:0] w,
                                    logic pos, logic first);
    item_t it;
    it.feature_key = key;
    it.weight = w;
    it.label_positive = pos;
    it.first_of_scan = first;
    pending_items.push_back(it);
  endfunction

  // sorted keys with ties; heavy scans drive one sum into saturation
  function automatic int add_scan(int len, int pos_pct, bit heavy, bit opened);
    logic [KEY_W-1:0] key;
    key = $urandom;
    for (int i = 0; i < len; i++) begin
      if (i > 0 && $urandom_range(99) >= 30) key = key + $urandom_range(1, 1000);
      push_item(key, heavy ? 16'hFFFF - WEIGHT_W'($urandom_range(3)) : WEIGHT_W'($urandom),
                $urandom_range(99) < pos_pct, opened && i == 0);
    end
    return len;
  endfunction

  task automatic drain();
    while (pending_items.size() > 0 || item_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    logic [SUM_W-1:0] totals[6];
    int count;
    int pick;
    totals = '{24'h000000, 24'hFFFFFF, 24'h008000, 24'h008001, 24'h000000, 24'h010000};
    totals[4] = SUM_W'($urandom_range(24'hFFFFFF));
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset total of 1.0; key 0 right after reset must not count as a tie
    push_item(32'h0000_0000, 16'h0000, 1'b1, 1'b0);
    push_item(32'h0000_0000, 16'hFFFF, 1'b1, 1'b0);
    push_item(32'h0000_0001, 16'hFFFF, 1'b0, 1'b0);
    push_item(32'h0000_0001, 16'h0000, 1'b0, 1'b0);
    push_item(32'hFFFF_FFFF, 16'h8000, 1'b1, 1'b0);
    push_item(32'hFFFF_FFFF, 16'h1234, 1'b0, 1'b1);
    // error exactly one half, one above, one below
    push_item(32'h0000_000A, 16'h8000, 1'b1, 1'b1);
    push_item(32'h0000_000B, 16'h0000, 1'b0, 1'b0);
    push_item(32'h0000_0014, 16'h7FFF, 1'b1, 1'b1);
    push_item(32'h0000_0015, 16'h0000, 1'b1, 1'b0);
    push_item(32'h0000_001E, 16'h8001, 1'b1, 1'b1);
    push_item(32'h0000_001F, 16'h0001, 1'b0, 1'b0);
    push_item(32'hAAAA_AAAA, 16'hAAAA, 1'b0, 1'b1);
    push_item(32'h5555_5555, 16'h5555, 1'b1, 1'b0);
    push_item(32'h5555_5555, 16'hFFFF, 1'b0, 1'b0);
    push_item(32'h5555_5556, 16'hFFFF, 1'b0, 1'b0);
    push_item(32'h5555_5557, 16'h0000, 1'b1, 1'b0);
    drain();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct = (p < 2) ? 11 : (p < 4) ? 59 : 0;
      recv_idle_pct = (p < 2) ? 59 : (p < 4) ? 11 : 0;
      write_total(totals[p]);
      count = 0;
      // positive saturation with total 0, negative saturation with full total
      if (p == 0) count += add_scan(280, 100, 1'b1, 1'b1);
      if (p == 1) count += add_scan(280, 0, 1'b1, 1'b1);
      if (p == 4) count += add_scan(280, $urandom_range(1) ? 100 : 0, 1'b1, 1'b1);
      while (count < 180) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          count += add_scan($urandom_range(1, 40), $urandom_range(100), 1'b0, 1'b1);
        end else if (pick < 90) begin
          count += add_scan($urandom_range(1, 10), $urandom_range(100), 1'b0, 1'b0);
        end else begin
          push_item($urandom, WEIGHT_W'($urandom), 1'($urandom_range(1)),
                    $urandom_range(3) == 0);
          count++;
        end
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

>>> stump_threshold_error_scan.f
design/stes_pkg.sv
design/stump_threshold_error_scan.sv
bench/tb_stump_threshold_error_scan.sv
